// ===== rtl/aip_pkg.sv =====
// Shared types, codes and constants for the ASCII integer parser.
`timescale 1ns / 1ps

package aip_pkg;

   // Character counter saturation limit and the counter width it needs
   localparam int unsigned COUNT_MAX   = 255;
   localparam int unsigned COUNT_WIDTH = $clog2(COUNT_MAX + 1);

   // Widths of the transfer fields and the register port
   localparam int unsigned CHAR_WIDTH   = 8;
   localparam int unsigned VALUE_WIDTH  = 64;
   localparam int unsigned OUT_CNT_WIDTH = 8;
   localparam int unsigned OUT_CNT_MAX   = 255;
   localparam int unsigned CSR_IDX_WIDTH  = 2;
   localparam int unsigned CSR_DATA_WIDTH = 2;

   // ASCII codes the parser reacts to
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SEVEN = 8'h37;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;

   // Range limits of the result formats
   localparam logic [VALUE_WIDTH-1:0] LIMIT_U32     = 64'h0000_0000_FFFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_I32_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_I32_NEG = 64'h0000_0000_8000_0000;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_I64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_I64_NEG = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DIGITS = 2'd1,
      STATUS_BAD_CHAR  = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FMT_U32 = 2'd0,
      FMT_U64 = 2'd1,
      FMT_I32 = 2'd2,
      FMT_I64 = 2'd3
   } format_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_NUMBER_FORMAT = 2'd0,
      CSR_OCTAL_BASE    = 2'd1,
      CSR_PREFIX_MODE   = 2'd2,
      CSR_ALLOW_PLUS    = 2'd3
   } csr_index_type;

   // Largest magnitude allowed for a format and sign
   function automatic logic [VALUE_WIDTH-1:0] format_limit(input format_type fmt,
                                                           input logic negative);
      logic [VALUE_WIDTH-1:0] lim;
      unique case (fmt)
         FMT_U32: lim = LIMIT_U32;
         FMT_U64: lim = LIMIT_U64;
         FMT_I32: lim = negative ? LIMIT_I32_NEG : LIMIT_I32_POS;
         FMT_I64: lim = negative ? LIMIT_I64_NEG : LIMIT_I64_POS;
         default: lim = LIMIT_U64;
      endcase
      return lim;
   endfunction

endpackage

// ===== rtl/aip_channels_if.sv =====
// Valid/ready channel interfaces for the parser's character and result transfers.
`timescale 1ns / 1ps

interface aip_req_if;
   logic                             valid;
   logic                             ready;
   logic [aip_pkg::CHAR_WIDTH-1:0]   char_code;
   logic                             last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
   modport monitor (input valid, input char_code, input last_char, input ready);
endinterface

interface aip_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [aip_pkg::VALUE_WIDTH-1:0]    parsed_value;
   logic [1:0]                         parse_status;
   logic [aip_pkg::OUT_CNT_WIDTH-1:0]  chars_consumed;

   modport source (output valid, output parsed_value, output parse_status,
                   output chars_consumed, input ready);
   modport sink   (input valid, input parsed_value, input parse_status,
                   input chars_consumed, output ready);
   modport monitor (input valid, input parsed_value, input parse_status,
                    input chars_consumed, input ready);
endinterface

// ===== rtl/ascii_integer_parser_top.sv =====
// The result is registered: it appears in the cycle after the transfer of the last character.
// Throughput: one character per cycle; the multiply by 8 or 10, the digit add
// and the range compare of the 64-bit accumulator form one combinational path.
// A new character is taken whenever the result register is empty or drains.
// Reset is synchronous and active high: it clears the parse state, drops any
// pending result and restores format u64, decimal, whole-string, plus allowed.
`timescale 1ns / 1ps

module ascii_integer_parser_top (
   input  logic                                  clock,
   input  logic                                  reset,
   aip_req_if.sink                               req_chan,
   aip_rsp_if.source                             rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [aip_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [aip_pkg::CSR_DATA_WIDTH-1:0]    csr_wr_data
);

   localparam int unsigned VW = aip_pkg::VALUE_WIDTH;
   localparam int unsigned CW = aip_pkg::COUNT_WIDTH;

   // Configuration registers
   aip_pkg::format_type number_format_ff;
   logic                octal_base_ff;
   logic                prefix_mode_ff;
   logic                allow_plus_ff;

   // Parse state
   logic [VW-1:0]       magnitude_ff, magnitude_in;
   logic                negative_ff, negative_in;
   logic [CW-1:0]       position_ff, position_in;
   logic                digit_seen_ff, digit_seen_in;
   logic                stopped_ff, stopped_in;
   aip_pkg::status_type error_ff, error_in;

   // Result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                        rsp_value_ff, rsp_value_in;
   aip_pkg::status_type                  rsp_status_ff, rsp_status_in;
   logic [aip_pkg::OUT_CNT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;

   logic                    req_fire;
   logic                    active;
   logic                    is_sign;
   logic                    is_digit;
   logic [7:0]              top_char;
   logic [3:0]              digit;
   logic [VW+3:0]           product;
   logic [VW+4:0]           candidate;
   logic [VW-1:0]           limit;
   logic                    overflow;
   logic [CW-1:0]           position_inc;
   logic [CW+7:0]           position_wide;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.parsed_value   = rsp_value_ff;
   assign rsp_chan.parse_status   = rsp_status_ff;
   assign rsp_chan.chars_consumed = rsp_count_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         number_format_ff <= aip_pkg::FMT_U64;
         octal_base_ff    <= 1'b0;
         prefix_mode_ff   <= 1'b0;
         allow_plus_ff    <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (aip_pkg::csr_index_type'(csr_index))
            aip_pkg::CSR_NUMBER_FORMAT: begin
               number_format_ff <= aip_pkg::format_type'(csr_wr_data[1:0]);
            end
            aip_pkg::CSR_OCTAL_BASE:  octal_base_ff  <= csr_wr_data[0];
            aip_pkg::CSR_PREFIX_MODE: prefix_mode_ff <= csr_wr_data[0];
            aip_pkg::CSR_ALLOW_PLUS:  allow_plus_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Classify the incoming character
   always_comb begin
      active   = (error_ff == aip_pkg::STATUS_OK) && !stopped_ff;
      top_char = octal_base_ff ? aip_pkg::CHAR_SEVEN : aip_pkg::CHAR_NINE;
      is_sign  = (position_ff == '0) && number_format_ff[1] &&
                 ((req_chan.char_code == aip_pkg::CHAR_MINUS) ||
                  ((req_chan.char_code == aip_pkg::CHAR_PLUS) && allow_plus_ff));
      is_digit = (req_chan.char_code >= aip_pkg::CHAR_ZERO) &&
                 (req_chan.char_code <= top_char);
      digit    = req_chan.char_code[3:0];
   end

   // Scale the accumulator, add the digit and check the format range
   always_comb begin
      if (octal_base_ff) begin
         product = {1'b0, magnitude_ff, 3'b000};
      end else begin
         product = {1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0};
      end
      candidate = {1'b0, product} + {{(VW+1){1'b0}}, digit};
      limit     = aip_pkg::format_limit(number_format_ff, negative_ff);
      overflow  = candidate > {5'b00000, limit};
   end

   assign position_inc = (position_ff < CW'(aip_pkg::COUNT_MAX)) ?
                         position_ff + 1'b1 : position_ff;

   // Advance the parse state on each character transfer while parsing is active
   always_comb begin
      magnitude_in  = magnitude_ff;
      negative_in   = negative_ff;
      position_in   = position_ff;
      digit_seen_in = digit_seen_ff;
      stopped_in    = stopped_ff;
      error_in      = error_ff;
      if (req_fire && active) begin
         priority if (is_sign) begin
            negative_in = (req_chan.char_code == aip_pkg::CHAR_MINUS);
            position_in = position_inc;
         end else if (is_digit && overflow) begin
            error_in = aip_pkg::STATUS_RANGE;
         end else if (is_digit) begin
            magnitude_in  = candidate[VW-1:0];
            digit_seen_in = 1'b1;
            position_in   = position_inc;
         end else if (prefix_mode_ff) begin
            stopped_in = 1'b1;
         end else begin
            error_in = aip_pkg::STATUS_BAD_CHAR;
         end
      end
   end

   // Form the result from the updated state
   always_comb begin
      position_wide = {8'h00, position_in};
      rsp_count_in  = (position_wide > (CW + 8)'(aip_pkg::OUT_CNT_MAX)) ?
                      aip_pkg::OUT_CNT_WIDTH'(aip_pkg::OUT_CNT_MAX) :
                      position_wide[aip_pkg::OUT_CNT_WIDTH-1:0];
      rsp_value_in  = '0;
      priority if (error_in != aip_pkg::STATUS_OK) begin
         rsp_status_in = error_in;
      end else if (!digit_seen_in) begin
         rsp_status_in = aip_pkg::STATUS_NO_DIGITS;
      end else begin
         rsp_status_in = aip_pkg::STATUS_OK;
         rsp_value_in  = negative_in ? (VW'(0) - magnitude_in) : magnitude_in;
      end
      rsp_valid_in = (req_fire && req_chan.last_char) ||
                     (rsp_valid_ff && !rsp_chan.ready);
   end

   // Hold parse state; clear it after the last character
   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_chan.last_char)) begin
         magnitude_ff  <= '0;
         negative_ff   <= 1'b0;
         position_ff   <= '0;
         digit_seen_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         error_ff      <= aip_pkg::STATUS_OK;
      end else begin
         magnitude_ff  <= magnitude_in;
         negative_ff   <= negative_in;
         position_ff   <= position_in;
         digit_seen_ff <= digit_seen_in;
         stopped_ff    <= stopped_in;
         error_ff      <= error_in;
      end
   end

   // Load the result register on the last character
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_chan.last_char) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

endmodule

// ===== rtl/aip_checker.sv =====
// Port-level checks for the ASCII integer parser, bound to the top level.
`timescale 1ns / 1ps

module aip_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   aip_req_if.sink                               req_chan,
   aip_rsp_if.source                             rsp_chan
);

   // A stalled result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.parsed_value) &&
         $stable(rsp_chan.parse_status) && $stable(rsp_chan.chars_consumed))
      else $error("result changed while stalled");

   // The last character always produces a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.last_char |=> rsp_chan.valid)
      else $error("last character without result");

   // Any failing status carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.parse_status != aip_pkg::STATUS_OK) |->
         rsp_chan.parsed_value == '0)
      else $error("nonzero value on failed parse");

   // A good parse consumed at least one character
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.parse_status == aip_pkg::STATUS_OK) |->
         rsp_chan.chars_consumed != '0)
      else $error("good parse with no characters");

   // No result right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result present after reset");

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
